FILE: rtl/sha256_pkg.sv
`timescale 1ns / 1ps

package sha256_pkg;

    // Round constants of the compression function.
    localparam logic [31:0] K_ROUND [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Initial hash value of every message.
    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] LAST_BYTE  = 6'd63;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [2:0] LAST_WORD  = 3'd7;

    typedef logic [31:0] t_word;

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word big_sigma0(input t_word x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

FILE: rtl/sha256_byte_stream_hasher.sv
`timescale 1ns / 1ps

// SHA-256 hasher fed one message byte per request. A request carrying a
// byte is taken while idle; the request that completes a 64-byte block
// also starts its compression, which runs one round per cycle on a single
// shared round unit and keeps the input stalled through its 64 rounds and
// the chaining add. A request flagged end-of-message appends the padding one
// byte per cycle (64 - fill bytes, or 128 - fill when 56 or more bytes are
// pending, counting the 0x80 mark, zeros and the 8 length bytes), runs one or
// two compressions, then presents the eight digest words in order, word 0
// first, one per accepted output request. After the eighth word the hasher
// is ready for the next message. An end request without a byte is allowed
// and hashes an empty message when no bytes came before it.

module sha256_byte_stream_hasher
    import sha256_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ROUND,
        S_UPDATE,
        S_OUT
    } t_state;

    t_state      r_state;
    t_word       r_chain [8];
    t_word       r_v [8];
    t_word       r_w [16];
    logic [63:0] r_bit_count;
    logic [5:0]  r_fill;
    logic [5:0]  r_round;
    logic        r_final;
    logic        r_mark_sent;
    logic        r_len_phase;
    logic [2:0]  r_out_idx;

    logic        push_en;
    logic [7:0]  push_byte;
    t_word       n_t1;
    t_word       n_t2;
    t_word       n_w;

    // Byte source for the message window: input bytes or padding bytes.
    always_comb begin
        push_en   = 1'b0;
        push_byte = 8'h00;
        case (r_state)
            S_IDLE: begin
                push_en   = i_valid && i_byte_present;
                push_byte = i_data_byte;
            end
            S_PAD: begin
                push_en = 1'b1;
                if (!r_mark_sent) begin
                    push_byte = PAD_MARK;
                end else if (r_len_phase || (r_fill == LEN_POS)) begin
                    push_byte = r_bit_count[63:56];
                end else begin
                    push_byte = 8'h00;
                end
            end
            default: begin
                push_en   = 1'b0;
                push_byte = 8'h00;
            end
        endcase
    end

    // Shared round unit and message schedule step.
    always_comb begin
        n_t1 = r_v[7] + big_sigma1(r_v[4])
             + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
             + K_ROUND[r_round] + r_w[0];
        n_t2 = big_sigma0(r_v[0])
             + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
        n_w  = r_w[0] + small_sigma0(r_w[1]) + r_w[9] + small_sigma1(r_w[14]);
    end

    // Message window: bytes shift in at the bottom, words shift out in rounds.
    always_ff @(posedge i_clk) begin
        if (push_en) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= {r_w[i][23:0], r_w[i+1][31:24]};
            end
            r_w[15] <= {r_w[15][23:0], push_byte};
        end else if (r_state == S_ROUND) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= n_w;
        end
    end

    // Sequencer, working variables, chaining value and length.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_chain     <= H_INIT;
            r_bit_count <= '0;
            r_fill      <= '0;
            r_round     <= '0;
            r_final     <= 1'b0;
            r_mark_sent <= 1'b0;
            r_len_phase <= 1'b0;
            r_out_idx   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_byte_present) begin
                            r_bit_count <= r_bit_count + 64'd8;
                        end
                        if (i_end_of_message) begin
                            r_final <= 1'b1;
                            // A request that completes a block compresses it
                            // first; the padding follows after the update.
                            if (!(i_byte_present && (r_fill == LAST_BYTE))) begin
                                r_state <= S_PAD;
                            end
                        end
                    end
                end
                S_PAD: begin
                    if (!r_mark_sent) begin
                        r_mark_sent <= 1'b1;
                    end else if (r_len_phase || (r_fill == LEN_POS)) begin
                        r_len_phase <= 1'b1;
                        r_bit_count <= {r_bit_count[55:0], 8'h00};
                    end
                end
                S_ROUND: begin
                    r_v[7]  <= r_v[6];
                    r_v[6]  <= r_v[5];
                    r_v[5]  <= r_v[4];
                    r_v[4]  <= r_v[3] + n_t1;
                    r_v[3]  <= r_v[2];
                    r_v[2]  <= r_v[1];
                    r_v[1]  <= r_v[0];
                    r_v[0]  <= n_t1 + n_t2;
                    r_round <= r_round + 6'd1;
                    if (r_round == LAST_ROUND) begin
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    for (int i = 0; i < 8; i++) begin
                        r_chain[i] <= r_chain[i] + r_v[i];
                    end
                    if (r_len_phase) begin
                        r_out_idx <= '0;
                        r_state   <= S_OUT;
                    end else if (r_final) begin
                        r_state <= S_PAD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_out_idx <= r_out_idx + 3'd1;
                        if (r_out_idx == LAST_WORD) begin
                            r_chain     <= H_INIT;
                            r_final     <= 1'b0;
                            r_mark_sent <= 1'b0;
                            r_len_phase <= 1'b0;
                            r_state     <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // A byte fills the block; the last one starts the compression.
            if (push_en) begin
                r_fill <= r_fill + 6'd1;
                if (r_fill == LAST_BYTE) begin
                    r_v     <= r_chain;
                    r_round <= '0;
                    r_state <= S_ROUND;
                end
            end
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_digest_word = r_chain[r_out_idx];
    assign o_word_index  = r_out_idx;
    assign o_last_word   = (r_out_idx == LAST_WORD);

endmodule
